// ===== hw/rtl/oic_pkg.sv =====
// ----------------------------------------------------------------------------
// oic_pkg: shared types and constants for the online island counter
// Grid geometry, cell index widths and the beat payload structs.
// ----------------------------------------------------------------------------
package oic_pkg;
    localparam int MAX_ROWS  = 64;
    localparam int MAX_COLS  = 64;
    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int CELLS     = MAX_ROWS * MAX_COLS;
    localparam int IDX_W     = $clog2(CELLS);
    localparam int RANK_W    = 4;
    localparam int CNT_W     = 13;
    localparam int DIM_W     = 7;
    localparam int ADDR_W    = 3;

    localparam logic [ADDR_W-1:0] REG_GRID_ROWS = 3'd0;
    localparam logic [ADDR_W-1:0] REG_GRID_COLS = 3'd4;

    typedef struct packed {
        logic [ROW_W-1:0] cell_row;
        logic [COL_W-1:0] cell_col;
    } oic_in_t;

    typedef struct packed {
        logic [CNT_W-1:0] island_count;
        logic             bad_cell;
    } oic_out_t;

    typedef struct packed {
        logic [DIM_W-1:0] rows;
        logic [DIM_W-1:0] cols;
    } oic_cfg_t;
endpackage

// ===== hw/rtl/oic_ram.sv =====
// ----------------------------------------------------------------------------
// oic_ram: generic single-port synchronous RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module oic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== hw/rtl/oic_regs.sv =====
// ----------------------------------------------------------------------------
// oic_regs: APB register file
// Holds grid_rows and grid_cols.
// ----------------------------------------------------------------------------
module oic_regs (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [oic_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    output oic_pkg::oic_cfg_t        cfg
);
    import oic_pkg::*;

    logic [DIM_W-1:0] rows_reg;
    logic [DIM_W-1:0] cols_reg;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= DIM_W'(MAX_ROWS);
            cols_reg <= DIM_W'(MAX_COLS);
        end
        else if (wr_en)
        begin
            if (paddr == REG_GRID_ROWS)
            begin
                rows_reg <= pwdata[DIM_W-1:0];
            end
            if (paddr == REG_GRID_COLS)
            begin
                cols_reg <= pwdata[DIM_W-1:0];
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == REG_GRID_ROWS)
        begin
            prdata = {{(32-DIM_W){1'b0}}, rows_reg};
        end
        else if (paddr == REG_GRID_COLS)
        begin
            prdata = {{(32-DIM_W){1'b0}}, cols_reg};
        end
    end

    assign cfg.rows = rows_reg;
    assign cfg.cols = cols_reg;
endmodule

// ===== hw/rtl/oic_core.sv =====
// ----------------------------------------------------------------------------
// oic_core: union-find sequencer
// Walks parent chains in the memories, compresses them, joins roots by rank.
// ----------------------------------------------------------------------------
module oic_core (
    input  logic              clk,
    input  logic              rst_n,
    input  oic_pkg::oic_cfg_t cfg,
    input  logic              start,
    input  oic_pkg::oic_in_t  cmd,
    output logic              busy,
    output logic              done,
    output oic_pkg::oic_out_t result
);
    import oic_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_CLR, S_CHK, S_CHK_W, S_INIT,
        S_NB, S_NB_W, S_FA, S_FA_W, S_CA, S_CA_W, S_FB, S_FB_W, S_CB, S_CB_W,
        S_RKA, S_RKA_W, S_RKB, S_RKB_W, S_JOIN, S_NEXT, S_OUT
    } state_t;

    state_t            st_reg;
    logic [IDX_W:0]    clr_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [COL_W-1:0]  col_reg;
    logic [IDX_W-1:0]  me_reg, nb_reg, ptr_reg, ra_reg, rb_reg;
    logic [RANK_W-1:0] rka_reg;
    logic [1:0]        dir_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              bad_reg;
    logic              done_reg;

    logic              land_we, land_wd, land_rd;
    logic [IDX_W-1:0]  land_a;
    logic              par_we;
    logic [IDX_W-1:0]  par_a, par_wd, par_rd;
    logic              rk_we;
    logic [IDX_W-1:0]  rk_a;
    logic [RANK_W-1:0] rk_wd, rk_rd;

    logic [DIM_W-1:0]  rows_eff, cols_eff;
    logic [DIM_W:0]    nr, nc;
    logic              nb_ok;

    oic_ram #(.WIDTH(1), .DEPTH(CELLS)) u_land (
        .clk(clk), .we(land_we), .addr(land_a), .wdata(land_wd), .rdata(land_rd));
    oic_ram #(.WIDTH(IDX_W), .DEPTH(CELLS)) u_par (
        .clk(clk), .we(par_we), .addr(par_a), .wdata(par_wd), .rdata(par_rd));
    oic_ram #(.WIDTH(RANK_W), .DEPTH(CELLS)) u_rank (
        .clk(clk), .we(rk_we), .addr(rk_a), .wdata(rk_wd), .rdata(rk_rd));

    assign rows_eff = (cfg.rows > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : cfg.rows;
    assign cols_eff = (cfg.cols > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : cfg.cols;

    // neighbor coordinates, one extra bit catches the wrap below zero
    always_comb
    begin
        nr = {1'b0, DIM_W'(row_reg)};
        nc = {1'b0, DIM_W'(col_reg)};
        unique case (dir_reg)
            2'd0: nr = nr - 1'b1;
            2'd1: nc = nc + 1'b1;
            2'd2: nr = nr + 1'b1;
            2'd3: nc = nc - 1'b1;
        endcase
        nb_ok = !nr[DIM_W] && !nc[DIM_W] && (nr[DIM_W-1:0] < rows_eff)
                && (nc[DIM_W-1:0] < cols_eff);
    end

    always_comb
    begin
        land_we = 1'b0; land_wd = 1'b0; land_a = me_reg;
        par_we = 1'b0; par_wd = ptr_reg; par_a = ptr_reg;
        rk_we = 1'b0; rk_wd = '0; rk_a = ra_reg;
        unique case (st_reg)
            S_CLR:
            begin
                land_we = 1'b1;
                land_a  = clr_reg[IDX_W-1:0];
            end
            S_INIT:
            begin
                land_we = 1'b1; land_wd = 1'b1;
                par_we = 1'b1; par_a = me_reg; par_wd = me_reg;
                rk_we = 1'b1; rk_a = me_reg;
            end
            S_NB: land_a = {nr[ROW_W-1:0], nc[COL_W-1:0]};
            S_FA, S_FB: par_a = ptr_reg;
            S_CA:
            begin
                par_a = ptr_reg;
                par_we = (ptr_reg != ra_reg);
                par_wd = ra_reg;
            end
            S_CB:
            begin
                par_a = ptr_reg;
                par_we = (ptr_reg != rb_reg);
                par_wd = rb_reg;
            end
            S_RKA: rk_a = ra_reg;
            // hold the address so the rank of rb is still on rk_rd in S_JOIN
            S_RKB, S_RKB_W: rk_a = rb_reg;
            S_JOIN:
            begin
                par_we = 1'b1;
                if (rka_reg < rk_rd)
                begin
                    par_a = ra_reg; par_wd = rb_reg;
                end
                else
                begin
                    par_a = rb_reg; par_wd = ra_reg;
                    if (rka_reg == rk_rd && rka_reg != {RANK_W{1'b1}})
                    begin
                        rk_we = 1'b1; rk_a = ra_reg; rk_wd = rka_reg + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_CLR;
            clr_reg  <= '0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
            bad_reg  <= 1'b0;
            dir_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (st_reg)
                S_CLR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (IDX_W+1)'(CELLS - 1))
                    begin
                        st_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        row_reg <= cmd.cell_row;
                        col_reg <= cmd.cell_col;
                        me_reg  <= {cmd.cell_row, cmd.cell_col};
                        bad_reg <= (DIM_W'(cmd.cell_row) >= rows_eff)
                                   || (DIM_W'(cmd.cell_col) >= cols_eff);
                        dir_reg <= '0;
                        st_reg  <= S_CHK;
                    end
                end
                S_CHK: st_reg <= bad_reg ? S_OUT : S_CHK_W;
                S_CHK_W:
                begin
                    if (land_rd)
                    begin
                        st_reg <= S_OUT;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                        st_reg  <= S_INIT;
                    end
                end
                S_INIT: st_reg <= S_NB;
                S_NB:
                begin
                    nb_reg <= {nr[ROW_W-1:0], nc[COL_W-1:0]};
                    st_reg <= nb_ok ? S_NB_W : S_NEXT;
                end
                S_NB_W:
                begin
                    ptr_reg <= me_reg;
                    st_reg  <= land_rd ? S_FA : S_NEXT;
                end
                S_FA: st_reg <= S_FA_W;
                S_FA_W:
                begin
                    if (par_rd == ptr_reg)
                    begin
                        ra_reg  <= ptr_reg;
                        ptr_reg <= me_reg;
                        st_reg  <= S_CA;
                    end
                    else
                    begin
                        ptr_reg <= par_rd;
                        st_reg  <= S_FA;
                    end
                end
                // compress: read parent, overwrite with root, follow old link
                S_CA: st_reg <= S_CA_W;
                S_CA_W:
                begin
                    if (ptr_reg == ra_reg)
                    begin
                        ptr_reg <= nb_reg;
                        st_reg  <= S_FB;
                    end
                    else
                    begin
                        ptr_reg <= par_rd;
                        st_reg  <= S_CA;
                    end
                end
                S_FB: st_reg <= S_FB_W;
                S_FB_W:
                begin
                    if (par_rd == ptr_reg)
                    begin
                        rb_reg  <= ptr_reg;
                        ptr_reg <= nb_reg;
                        st_reg  <= S_CB;
                    end
                    else
                    begin
                        ptr_reg <= par_rd;
                        st_reg  <= S_FB;
                    end
                end
                S_CB: st_reg <= S_CB_W;
                S_CB_W:
                begin
                    if (ptr_reg == rb_reg)
                    begin
                        st_reg <= (ra_reg != rb_reg) ? S_RKA : S_NEXT;
                    end
                    else
                    begin
                        ptr_reg <= par_rd;
                        st_reg  <= S_CB;
                    end
                end
                S_RKA: st_reg <= S_RKA_W;
                S_RKA_W:
                begin
                    rka_reg <= rk_rd;
                    st_reg  <= S_RKB;
                end
                S_RKB: st_reg <= S_RKB_W;
                S_RKB_W: st_reg <= S_JOIN;
                S_JOIN:
                begin
                    if (cnt_reg != '0)
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                    st_reg <= S_NEXT;
                end
                S_NEXT:
                begin
                    dir_reg <= dir_reg + 1'b1;
                    st_reg  <= (dir_reg == 2'd3) ? S_OUT : S_NB;
                end
                S_OUT:
                begin
                    done_reg <= 1'b1;
                    st_reg   <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    assign busy                = (st_reg != S_IDLE);
    assign done                = done_reg;
    assign result.island_count = cnt_reg;
    assign result.bad_cell     = bad_reg;
endmodule

// ===== hw/rtl/online_island_counter_top.sv =====
// ----------------------------------------------------------------------------
// online_island_counter_top: online island counter
// Counts 4-connected islands as grid cells turn into land.
// ----------------------------------------------------------------------------
// After reset the block clears its land memory with busy high. Raise start
// while busy is low; busy rises the next cycle. In the first cycle that busy
// is low again, done is high for one cycle with the result. The receiver
// cannot stall. An out-of-range cell goes from S_CHK to S_OUT and a cell
// already land from S_CHK through S_CHK_W to S_OUT. A new cell is set in
// S_INIT, then each neighbor is visited: one outside the grid or water is
// skipped; for a land neighbor both root chains get a find and a compress
// pass (a read and a wait per node), and differing roots are joined by rank.
module online_island_counter_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  oic_pkg::oic_in_t           cmd,
    output logic                       busy,
    output logic                       done,
    output oic_pkg::oic_out_t          result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [oic_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import oic_pkg::*;

    oic_cfg_t cfg;

    oic_regs u_regs (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg));

    oic_core u_core (
        .clk(clk), .rst_n(rst_n), .cfg(cfg), .start(start), .cmd(cmd),
        .busy(busy), .done(done), .result(result));
endmodule

// ===== hw/rtl/oic_checker.sv =====
// ----------------------------------------------------------------------------
// oic_checker: port-level checks for the online island counter
// Watches handshake and result behavior over time.
// ----------------------------------------------------------------------------
module oic_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input oic_pkg::oic_out_t result
);
    import oic_pkg::*;

    // an accepted beat makes the block busy
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("busy did not rise");

    // a result comes with the block idle again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("busy during result");

    // done is not held: each result beat is a pulse
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("result held too long");

    // a flagged cell leaves the count alone
    a_bad_hold: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.bad_cell |-> $stable(result.island_count))
        else $error("count moved on bad cell");
endmodule

bind online_island_counter_top oic_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done), .result(result));
